>>> design/ffsa_pkg.sv
package ffsa_pkg;

  localparam int MaxSeg = 64;
  localparam int IdxW = $clog2(MaxSeg);
  localparam int CntW = $clog2(MaxSeg + 1);

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoFit   = 3'd1;
  localparam logic [2:0] StZero    = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StBadFree = 3'd4;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] request_size;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_offset;
    logic [15:0] granted_size;
  } rsp_t;

  // one table entry: start, length, in-use mark
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
    logic        used;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_SEARCH,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_SPLIT_FIN,
    S_DEL_RD,
    S_DEL_WR,
    S_FREE_CHK,
    S_FREE_NXT,
    S_FREE_PRV,
    S_DONE
  } state_e;

endpackage

>>> design/first_fit_segment_allocator.sv
// First-fit segment allocator. The segment table lives in a 64-entry memory
// with one write and one registered read port, walked by a small sequencer
// one entry at a time. After reset and after every write of the total size
// (cfg_we_i) the table is cleared in a pass over all 64 entries (no transfer
// accepted meanwhile). The search reads and checks each entry in turn; an
// allocate that splits then shifts every later entry up one slot. A free
// then checks its next and previous neighbours, and when a merge removes
// entries the gap is closed slot by slot from the freed entry to the end of
// the 64-entry table. in_ready_o is high only while the sequencer is idle
// and the result register is empty or being drained.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  seg_t mem_q [MaxSeg];
  seg_t rd_q;

  state_e state_q, state_d;
  logic [15:0]   total_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] i_q, i_d, k_q, k_d;
  req_t          req_q;
  logic          req_ld;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_v_q, rsp_v_d;
  seg_t          hold_q, hold_d;   // entry at k, carried through moves
  seg_t          carry_q, carry_d; // entry being shifted up
  logic          we;
  logic [IdxW-1:0] wa, ra;
  seg_t          wd;
  logic          merged_q, merged_d;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
    if (req_ld) req_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      total_q  <= 16'd1024;
      cnt_q    <= '0;
      i_q      <= '0;
      k_q      <= '0;
      rsp_v_q  <= 1'b0;
      merged_q <= 1'b0;
    end else begin
      state_q  <= cfg_we_i ? S_CLEAR : state_d;
      if (cfg_we_i) total_q <= cfg_wdata_i;
      cnt_q    <= cnt_d;
      i_q      <= cfg_we_i ? '0 : i_d;
      k_q      <= k_d;
      rsp_v_q  <= rsp_v_d;
      merged_q <= merged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    hold_q  <= hold_d;
    carry_q <= carry_d;
  end

  logic [IdxW-1:0] i_nx;
  logic [CntW-1:0] i_ext, k_ext;
  assign i_nx  = i_q + 1'b1;
  assign i_ext = CntW'(i_q);
  assign k_ext = CntW'(k_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    k_d      = k_q;
    rsp_d    = rsp_q;
    rsp_v_d  = rsp_v_q;
    hold_d   = hold_q;
    carry_d  = carry_q;
    merged_d = merged_q;
    we       = 1'b0;
    wa       = i_q;
    wd       = '0;
    ra       = i_q;
    req_ld   = 1'b0;
    in_ready_o = 1'b0;
    if (rsp_v_q && out_ready_i) rsp_v_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wd = (i_q == '0) ? seg_t'{start: 16'd0, len: total_q, used: 1'b0} : '0;
        cnt_d = CntW'(1);
        i_d = i_nx;
        if (i_q == IdxW'(MaxSeg - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !rsp_v_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          req_ld = 1'b1;
          i_d = '0;
          rsp_d = '0;
          if (in_data_i.func == FuncAlloc && in_data_i.request_size == 16'd0) begin
            rsp_d.status = StZero;
            state_d = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (i_ext >= cnt_q) begin
          rsp_d.status = (req_q.func == FuncAlloc) ? StNoFit : StBadFree;
          state_d = S_DONE;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // rd_q holds entry i
        k_d = i_q;
        hold_d = rd_q;
        state_d = S_RD;
        i_d = i_nx;
        // last slot of a full table: stop unless this entry matches
        if (i_q == IdxW'(MaxSeg - 1)) begin
          rsp_d.status = (req_q.func == FuncAlloc) ? StNoFit : StBadFree;
          state_d = S_DONE;
        end
        if (req_q.func == FuncAlloc) begin
          if (!rd_q.used && rd_q.len >= req_q.request_size) begin
            if (rd_q.len > req_q.request_size && cnt_q >= CntW'(MaxSeg)) begin
              rsp_d.status = StFull;
              state_d = S_DONE;
            end else begin
              rsp_d.status = StOk;
              rsp_d.granted_offset = rd_q.start;
              rsp_d.granted_size = req_q.request_size;
              we = 1'b1;
              wa = i_q;
              wd = '{start: rd_q.start, len: req_q.request_size, used: 1'b1};
              if (rd_q.len > req_q.request_size) begin
                carry_d = '{start: rd_q.start + req_q.request_size,
                            len: rd_q.len - req_q.request_size, used: 1'b0};
                state_d = S_SPLIT_RD;
              end else begin
                state_d = S_DONE;
              end
            end
          end
        end else if (rd_q.used && rd_q.start == req_q.block_offset) begin
          rsp_d.status = StOk;
          hold_d.used = 1'b0;
          merged_d = 1'b0;
          state_d = S_FREE_CHK;
        end
      end
      // insert carry at i, shifting later entries up one
      S_SPLIT_RD: begin
        ra = i_q;
        state_d = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        we = 1'b1;
        wa = i_q;
        wd = carry_q;
        carry_d = rd_q;
        i_d = i_nx;
        if (i_ext >= cnt_q) begin
          cnt_d = cnt_q + 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SPLIT_RD;
        end
      end
      S_SPLIT_FIN: state_d = S_DONE;
      // hold_q is freed entry k; read k+1
      S_FREE_CHK: begin
        ra = k_q + 1'b1;
        state_d = S_FREE_NXT;
      end
      S_FREE_NXT: begin
        if (k_ext + 1'b1 < cnt_q && !rd_q.used) begin
          hold_d.len = hold_q.len + rd_q.len;
          merged_d = 1'b1;
          i_d = k_q + 1'b1;
        end
        ra = k_q - 1'b1;
        state_d = S_FREE_PRV;
      end
      S_FREE_PRV: begin
        if (k_q != '0 && !rd_q.used) begin
          // fold into previous entry; entry k then goes away
          we = 1'b1;
          wa = k_q - 1'b1;
          wd = '{start: rd_q.start, len: rd_q.len + hold_q.len, used: 1'b0};
          if (merged_q) begin
            cnt_d = cnt_q - 2'd2;
            i_d = k_q;
            k_d = k_q + 1'b1; // shift distance 2 encoded by source = i+2
            carry_d.used = 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
            i_d = k_q;
            k_d = k_q;
            carry_d.used = 1'b0;
          end
          state_d = S_DEL_RD;
        end else begin
          we = 1'b1;
          wa = k_q;
          wd = hold_q;
          if (merged_q) begin
            cnt_d = cnt_q - 1'b1;
            i_d = k_q + 1'b1;
            carry_d.used = 1'b0;
            state_d = S_DEL_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // close the gap: entry i takes entry i+1 (or i+2 when carry.used)
      S_DEL_RD: begin
        ra = carry_q.used ? i_q + 2'd2 : i_q + 1'b1;
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        we = 1'b1;
        wa = i_q;
        wd = (i_ext >= cnt_q) ? '0 : rd_q;
        i_d = i_nx;
        if (i_q == IdxW'(MaxSeg - 1)) state_d = S_DONE;
        else state_d = S_DEL_RD;
      end
      S_DONE: begin
        if (!rsp_v_q || out_ready_i) begin
          rsp_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = rsp_v_q;
  assign out_data_o  = rsp_q;

endmodule

>>> tb/first_fit_segment_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_data_o;

  first_fit_segment_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // shadow of the segment table
  logic [15:0] seg_start [MaxSeg];
  logic [15:0] seg_len   [MaxSeg];
  logic        seg_used  [MaxSeg];
  int          seg_cnt;
  logic [15:0] mem_total;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors;
  int   cycles;
  int   hold_off;
  int   send_gap;
  int   recv_gap;
  bit   in_fire;

  function automatic void table_reset(logic [15:0] total);
    for (int i = 0; i < MaxSeg; i++) begin
      seg_start[i] = '0;
      seg_len[i]   = '0;
      seg_used[i]  = 1'b0;
    end
    seg_len[0] = total;
    seg_cnt    = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < seg_cnt; i++) begin
      seg_start[i] = seg_start[i+1];
      seg_len[i]   = seg_len[i+1];
      seg_used[i]  = seg_used[i+1];
    end
    seg_cnt--;
    seg_start[seg_cnt] = '0;
    seg_len[seg_cnt]   = '0;
    seg_used[seg_cnt]  = 1'b0;
  endfunction

  function automatic void coalesce(int k);
    if (k + 1 >= seg_cnt) return;
    if (seg_used[k] || seg_used[k+1]) return;
    seg_len[k] = seg_len[k] + seg_len[k+1];
    drop_entry(k + 1);
  endfunction

  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int   k;
    o = '0;
    o.status = StOk;
    k = seg_cnt;
    if (r.func == FuncAlloc) begin
      if (r.request_size == 0) begin
        o.status = StZero;
      end else begin
        for (int i = 0; i < seg_cnt; i++)
          if (!seg_used[i] && seg_len[i] >= r.request_size && k == seg_cnt) k = i;
        if (k >= seg_cnt) begin
          o.status = StNoFit;
        end else if (seg_len[k] > r.request_size && seg_cnt >= MaxSeg) begin
          o.status = StFull;
        end else begin
          if (seg_len[k] > r.request_size) begin
            for (int i = seg_cnt; i > k + 1; i--) begin
              seg_start[i] = seg_start[i-1];
              seg_len[i]   = seg_len[i-1];
              seg_used[i]  = seg_used[i-1];
            end
            seg_start[k+1] = seg_start[k] + r.request_size;
            seg_len[k+1]   = seg_len[k] - r.request_size;
            seg_used[k+1]  = 1'b0;
            seg_len[k]     = r.request_size;
            seg_cnt++;
          end
          seg_used[k]      = 1'b1;
          o.granted_offset = seg_start[k];
          o.granted_size   = r.request_size;
        end
      end
    end else begin
      for (int i = 0; i < seg_cnt; i++)
        if (seg_used[i] && seg_start[i] == r.block_offset && k == seg_cnt) k = i;
      if (k >= seg_cnt) begin
        o.status = StBadFree;
      end else begin
        seg_used[k] = 1'b0;
        coalesce(k);
        if (k > 0) coalesce(k - 1);
      end
    end
    return o;
  endfunction

  // offsets currently allocated, tracked at queue-fill time
  logic [15:0] live_offs[$];

  function automatic req_t mk_alloc(int sz);
    req_t r;
    r.func         = FuncAlloc;
    r.request_size = sz[15:0];
    r.block_offset = 16'($urandom);
    return r;
  endfunction

  function automatic req_t mk_free(logic [15:0] off);
    req_t r;
    r.func         = FuncFree;
    r.request_size = 16'($urandom);
    r.block_offset = off;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_fire) begin
      // transfer happened at the last rising edge
      void'(pending_reqs.pop_front());
      send_gap = $urandom_range(0, 8);
      if (send_gap == 0 && pending_reqs.size() > 0) begin
        in_data_i <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      recv_gap = $urandom_range(0, 8);
      out_ready_i <= (recv_gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready_i <= (recv_gap == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // input monitor: predict on accept
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (in_fire)
      expected_rsps.push_back(allocate_or_free(in_data_i));
  end

  // output monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_data_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.granted_offset !== e.granted_offset) begin
          $error("granted_offset exp %0d got %0d", e.granted_offset,
                 out_data_o.granted_offset);
          errors++;
        end
        if (out_data_o.granted_size !== e.granted_size) begin
          $error("granted_size exp %0d got %0d", e.granted_size,
                 out_data_o.granted_size);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_total(logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mem_total = v;
    table_reset(v);
    live_offs.delete();
  endtask

  initial begin
    errors      = 0;
    hold_off    = 0;
    send_gap    = 0;
    recv_gap    = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    mem_total   = 16'd1024;
    table_reset(16'd1024);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed at reset value
    pending_reqs.push_back(mk_alloc(0));
    pending_reqs.push_back(mk_alloc(2000));
    pending_reqs.push_back(mk_alloc(16'hFFFF));
    pending_reqs.push_back(mk_alloc(100));
    pending_reqs.push_back(mk_alloc(200));
    pending_reqs.push_back(mk_free(100));
    pending_reqs.push_back(mk_free(100));
    pending_reqs.push_back(mk_free(16'hFFFF));
    pending_reqs.push_back(mk_alloc(50));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_alloc(1024));
    pending_reqs.push_back(mk_free(0));
    drain();

    // table full: many unit allocates on a small memory
    set_total(16'd80);
    for (int i = 0; i < 66; i++) pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(16));
    for (int i = 1; i < 64; i += 2) pending_reqs.push_back(mk_free(i[15:0]));
    for (int i = 0; i < 64; i += 2) pending_reqs.push_back(mk_free(i[15:0]));
    // receiver holds off while the sender keeps offering
    hold_off = 400;
    drain();

    set_total(16'd0);
    pending_reqs.push_back(mk_alloc(1));
    pending_reqs.push_back(mk_alloc(0));
    pending_reqs.push_back(mk_free(0));
    drain();

    set_total(16'hFFFF);
    pending_reqs.push_back(mk_alloc(16'hFFFF));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_alloc(16'h8000));
    pending_reqs.push_back(mk_alloc(16'h7FFF));
    pending_reqs.push_back(mk_free(16'h8000));
    pending_reqs.push_back(mk_free(0));
    drain();

    // random phases; frees mostly target offsets that are likely allocated
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_total(16'd1);
        1: set_total(16'd300);
        2: set_total(16'hFFFF);
        3: set_total(16'($urandom_range(1, 65535)));
        4: set_total(16'd64);
        default: set_total(16'd1024);
      endcase
      for (int i = 0; i < 300; i++) begin
        // snapshot-driven: predict granted offsets from the shadow table, reset afterwards
        if (seg_cnt > 0 && $urandom_range(0, 9) < 4 && live_offs.size() > 0) begin
          int j;
          j = $urandom_range(0, live_offs.size() - 1);
          pending_reqs.push_back(mk_free(live_offs[j]));
          void'(allocate_or_free(mk_free(live_offs[j])));
          live_offs.delete(j);
        end else if ($urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 2))
            0: pending_reqs.push_back(mk_alloc(0));
            1: pending_reqs.push_back(mk_free(16'($urandom)));
            default: pending_reqs.push_back(mk_alloc($urandom));
          endcase
          void'(allocate_or_free(pending_reqs[$]));
        end else begin
          rsp_t g;
          int   lim;
          lim = (mem_total > 16) ? mem_total / 8 : (mem_total == 0 ? 1 : mem_total);
          pending_reqs.push_back(mk_alloc($urandom_range(1, lim)));
          g = allocate_or_free(pending_reqs[$]);
          if (g.status == StOk) live_offs.push_back(g.granted_offset);
        end
      end
      // restore shadow for the monitor's own prediction
      table_reset(mem_total);
      if (ph == 2) begin
        // wait until all requests are sent and all results are back
        while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
          @(posedge clk_i);
        repeat (20) @(posedge clk_i);
      end
      drain();
    end

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ffsa_pkg.sv
design/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_tb.sv
